>>> hdl/sha256_pkg.sv
// SHA-256 digest package: round constants, initial hash, sigma functions,
// controller state type and the window control struct.
// No dependencies.
`timescale 1ns / 1ps

package sha256_pkg;

  localparam int unsigned NumRounds  = 64;
  localparam int unsigned NumWords   = 16;
  localparam int unsigned NumHash    = 8;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [5:0]  LenOffset  = 6'd56;
  localparam logic [5:0]  LastRound  = 6'd63;
  localparam logic [2:0]  LastWord   = 3'd7;

  localparam logic [31:0] RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [NumHash] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_e;

  // Commands to the message window
  typedef struct packed {
    logic wr_byte;
    logic pad;
    logic len_blk;
    logic shift;
  } sched_ctl_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

>>> hdl/sha256_sched.sv
// SHA-256 message window: gathers bytes into the 16-word block, applies the
// pad and length, then slides as the message schedule during the rounds.
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_sched (
  input  logic                   clk_i,
  input  sha256_pkg::sched_ctl_t ctl_i,
  input  logic [5:0]             pos_i,
  input  logic [7:0]             byte_i,
  input  logic [63:0]            bit_len_i,
  output logic [31:0]            w_t_o
);

  logic [31:0] w_q [sha256_pkg::NumWords];
  logic [31:0] w_d [sha256_pkg::NumWords];
  logic [31:0] w_new;
  logic [3:0]  wi;
  logic [1:0]  bi;

  assign wi    = pos_i[5:2];
  assign bi    = pos_i[1:0];
  assign w_t_o = w_q[0];

  // Next schedule word from the fixed window taps
  assign w_new = sha256_pkg::small_sigma1(w_q[14]) + w_q[9] +
                 sha256_pkg::small_sigma0(w_q[1]) + w_q[0];

  // Update the window: shift, byte write, pad or length-only block
  always_comb begin
    for (int i = 0; i < sha256_pkg::NumWords; i++) begin
      w_d[i] = w_q[i];
    end
    if (ctl_i.shift) begin
      for (int i = 0; i < sha256_pkg::NumWords - 1; i++) begin
        w_d[i] = w_q[i + 1];
      end
      w_d[sha256_pkg::NumWords - 1] = w_new;
    end else if (ctl_i.wr_byte) begin
      for (int b = 0; b < 4; b++) begin
        if (2'(b) == bi) begin
          w_d[wi][31 - 8 * b -: 8] = byte_i;
        end
      end
    end else if (ctl_i.pad) begin
      for (int i = 0; i < sha256_pkg::NumWords; i++) begin
        if (4'(i) > wi) begin
          w_d[i] = '0;
        end else if (4'(i) == wi) begin
          for (int b = 0; b < 4; b++) begin
            if (2'(b) == bi) begin
              w_d[i][31 - 8 * b -: 8] = sha256_pkg::PadByte;
            end else if (2'(b) > bi) begin
              w_d[i][31 - 8 * b -: 8] = 8'h00;
            end
          end
        end
      end
      // Length fits behind the pad in this block
      if (pos_i < sha256_pkg::LenOffset) begin
        w_d[14] = bit_len_i[63:32];
        w_d[15] = bit_len_i[31:0];
      end
    end else if (ctl_i.len_blk) begin
      for (int i = 0; i < sha256_pkg::NumWords; i++) begin
        w_d[i] = '0;
      end
      w_d[14] = bit_len_i[63:32];
      w_d[15] = bit_len_i[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < sha256_pkg::NumWords; i++) begin
      w_q[i] <= w_d[i];
    end
  end

endmodule

>>> hdl/sha256_round.sv
// SHA-256 round unit: the eight working variables and one compression round,
// reused once per cycle for all 64 rounds of a block.
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_round (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             step_i,
  input  logic [7:0][31:0] init_i,
  input  logic [31:0]      w_i,
  input  logic [31:0]      k_i,
  output logic [7:0][31:0] vars_o
);

  logic [7:0][31:0] v_q;
  logic [7:0][31:0] v_d;
  logic [31:0]      ch;
  logic [31:0]      maj;
  logic [31:0]      t1;
  logic [31:0]      t2;

  assign vars_o = v_q;

  // One round of the compression function
  always_comb begin
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + sha256_pkg::big_sigma1(v_q[4]) + ch + k_i + w_i;
    t2  = sha256_pkg::big_sigma0(v_q[0]) + maj;
    v_d = v_q;
    if (load_i) begin
      v_d = init_i;
    end else if (step_i) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

endmodule

>>> hdl/sha256_message_digest.sv
// SHA-256 digest top level: stream ports, controller, hash words and counters.
// Depends on sha256_pkg, sha256_sched and sha256_round.
//
//  channel   | dir | handshake            | payload
//  s_axis    | in  | s_axis_tvalid/tready | tdata=data_byte, tuser=byte_valid,
//            |     |                      | tlast=end_of_message
//  m_axis    | out | m_axis_tvalid/tready | tdata=digest_word, tuser=word_index,
//            |     |                      | tlast=last_word
//
// A byte request is taken while idle; the byte that fills a 64-byte block
// then runs 64 rounds in the shared round unit and one fold into the hash.
// An end request pads and compresses one block, or two when the length
// spills into an extra block, then sends eight words at the consumer's pace.
// Reset (rst_ni low, asynchronous) loads the initial hash and clears counters.
// s_axis_tready is low while a block compresses or the digest is delivered.
`timescale 1ns / 1ps

module sha256_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);

  sha256_pkg::state_e     state_q, state_d;
  sha256_pkg::state_e     ret_q, ret_d;
  sha256_pkg::sched_ctl_t ctl;
  logic [5:0]             rnd_q;
  logic [5:0]             pos_q;
  logic [60:0]            count_q;
  logic [2:0]             idx_q;
  logic [7:0][31:0]       hash_q;
  logic [7:0][31:0]       vars;
  logic [31:0]            w_t;
  logic                   load;
  logic                   step;
  logic                   fold;
  logic                   done;
  logic                   in_acc;
  logic                   byte_acc;
  logic                   out_acc;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign byte_acc = in_acc & s_axis_tuser;
  assign out_acc  = m_axis_tvalid & m_axis_tready;

  // Message window and schedule
  sha256_sched u_sched (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .pos_i     (pos_q),
    .byte_i    (s_axis_tdata),
    .bit_len_i ({count_q, 3'b000}),
    .w_t_o     (w_t)
  );

  // Shared round unit
  sha256_round u_round (
    .clk_i  (clk_i),
    .load_i (load),
    .step_i (step),
    .init_i (hash_q),
    .w_i    (w_t),
    .k_i    (sha256_pkg::RoundK[rnd_q]),
    .vars_o (vars)
  );

  // Next state and sequencer outputs
  always_comb begin
    state_d       = state_q;
    ret_d         = ret_q;
    ctl           = '0;
    load          = 1'b0;
    step          = 1'b0;
    fold          = 1'b0;
    done          = 1'b0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      sha256_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          ctl.wr_byte = s_axis_tuser;
          if (s_axis_tuser && pos_q == sha256_pkg::LastRound) begin
            load    = 1'b1;
            state_d = sha256_pkg::ST_COMP;
            ret_d   = s_axis_tlast ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
          end else if (s_axis_tlast) begin
            state_d = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        ctl.pad = 1'b1;
        load    = 1'b1;
        state_d = sha256_pkg::ST_COMP;
        ret_d   = (pos_q >= sha256_pkg::LenOffset) ? sha256_pkg::ST_LEN
                                                    : sha256_pkg::ST_OUT;
      end
      sha256_pkg::ST_LEN: begin
        ctl.len_blk = 1'b1;
        load        = 1'b1;
        state_d     = sha256_pkg::ST_COMP;
        ret_d       = sha256_pkg::ST_OUT;
      end
      sha256_pkg::ST_COMP: begin
        step      = 1'b1;
        ctl.shift = 1'b1;
        if (rnd_q == sha256_pkg::LastRound) begin
          state_d = sha256_pkg::ST_FOLD;
        end
      end
      sha256_pkg::ST_FOLD: begin
        fold    = 1'b1;
        state_d = ret_q;
      end
      sha256_pkg::ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready && idx_q == sha256_pkg::LastWord) begin
          done    = 1'b1;
          state_d = sha256_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sha256_pkg::ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::ST_IDLE;
      ret_q   <= sha256_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // Round counter: advance during compression, hold at zero otherwise
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
    end else if (step) begin
      rnd_q <= rnd_q + 6'd1;
    end else begin
      rnd_q <= '0;
    end
  end

  // Byte position and message length; drop both after the digest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      count_q <= '0;
    end else if (done) begin
      pos_q   <= '0;
      count_q <= '0;
    end else if (byte_acc) begin
      pos_q   <= pos_q + 6'd1;
      count_q <= count_q + 61'd1;
    end
  end

  // Hash words: fold in the working variables, restart after the digest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sha256_pkg::NumHash; i++) begin
        hash_q[i] <= sha256_pkg::InitHash[i];
      end
    end else if (fold) begin
      for (int i = 0; i < sha256_pkg::NumHash; i++) begin
        hash_q[i] <= hash_q[i] + vars[i];
      end
    end else if (done) begin
      for (int i = 0; i < sha256_pkg::NumHash; i++) begin
        hash_q[i] <= sha256_pkg::InitHash[i];
      end
    end
  end

  // Output word index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (out_acc) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  assign m_axis_tdata = hash_q[idx_q];
  assign m_axis_tuser = idx_q;
  assign m_axis_tlast = (idx_q == sha256_pkg::LastWord);

endmodule

>>> tb/sha256_message_digest_tb.sv
// Self-checking testbench for sha256_message_digest: byte stream in, digest words out.
// Holds its own SHA-256 predictor and compares every word; depends on sha256_pkg and the DUT.
`timescale 1ns / 1ps

module sha256_message_digest_tb;

  // Standard SHA-256 round constants and initial hash, kept apart from the RTL copy
  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0]  PadMark     = 8'h80;
  localparam logic [5:0]  LenSlot     = 6'd56;
  localparam int unsigned ItemBudget  = 280;
  localparam int unsigned QuietAfter  = 220;
  localparam int unsigned HoldAfter   = 80;   // digest words seen before the long hold
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 150;

  // Known digests, H0 in the top bits
  localparam logic [255:0] NoDigest    = 256'h0;
  localparam logic [255:0] EmptyDigest =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] AbcDigest   =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  // Message lengths around the pad and block boundaries
  localparam int unsigned EdgeLens [5] = '{55, 56, 63, 64, 65};

  typedef struct packed {
    logic [7:0]   data;
    logic         valid;
    logic         eom;
    logic         typed;    // digest column holds the known answer
    logic [255:0] digest;
  } dir_row_t;

  localparam int unsigned NumDirRows = 17;
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},  // empty message
    '{8'h5a, 1'b0, 1'b0, 1'b0, NoDigest},     // idle item
    '{8'h61, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h62, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},    // last byte rides on the end item
    '{8'hff, 1'b0, 1'b1, 1'b1, EmptyDigest},  // end marker, data byte ignored
    '{8'h61, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h62, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h63, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h00, 1'b0, 1'b1, 1'b1, AbcDigest},    // same message, separate end marker
    '{8'h00, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'hff, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'ha5, 1'b0, 1'b0, 1'b0, NoDigest},     // idle item inside a message
    '{8'h80, 1'b1, 1'b0, 1'b0, NoDigest},
    '{8'h00, 1'b0, 1'b1, 1'b0, NoDigest},
    '{8'hff, 1'b1, 1'b1, 1'b0, NoDigest},     // one-byte messages
    '{8'h00, 1'b1, 1'b1, 1'b0, NoDigest}
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        s_axis_tuser = 1'b0;    // [0] byte_valid
  logic        s_axis_tlast = 1'b0;    // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [31:0] digest_word
  logic [2:0]  m_axis_tuser;           // [2:0] word_index
  logic        m_axis_tlast;           // last_word

  // Predictor state
  logic [31:0] chain_hash [8];
  logic [31:0] msg_block [16];
  logic [5:0]  block_fill;
  logic [60:0] msg_len_bytes;

  digest_word_t pending_words [$];
  int unsigned  mismatches = 0;
  int unsigned  items_sent = 0;
  int unsigned  words_checked = 0;
  bit           quiet_tail = 1'b0;
  bit           sender_gaps = 1'b1;

  sha256_message_digest dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // Run the message schedule and 64 rounds over msg_block, fold into chain_hash
  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    end
    a = chain_hash[0]; b = chain_hash[1]; c = chain_hash[2]; d = chain_hash[3];
    e = chain_hash[4]; f = chain_hash[5]; g = chain_hash[6]; h = chain_hash[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + RoundConst[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
    chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
  endfunction

  function automatic void put_msg_byte(input logic [5:0] pos, input logic [7:0] val);
    msg_block[pos[5:2]][8 * (3 - int'(pos[1:0])) +: 8] = val;
  endfunction

  // Absorb one request; on an end request pad, finish and return 1 with the digest
  function automatic bit sha_absorb(input logic [7:0] d, input logic v, input logic e,
                                    output logic [255:0] digest);
    logic [63:0] bit_len;
    digest = '0;
    if (v) begin
      put_msg_byte(block_fill, d);
      block_fill    = block_fill + 6'd1;
      msg_len_bytes = msg_len_bytes + 61'd1;
      if (block_fill == 6'd0) sha_compress();
    end
    if (!e) return 1'b0;
    put_msg_byte(block_fill, PadMark);
    for (int p = int'(block_fill) + 1; p < 64; p++) put_msg_byte(6'(p), 8'h00);
    // Length does not fit: close this block and carry it in a zero block
    if (block_fill >= LenSlot) begin
      sha_compress();
      for (int i = 0; i < 16; i++) msg_block[i] = '0;
    end
    bit_len = {msg_len_bytes, 3'b000};
    msg_block[14] = bit_len[63:32];
    msg_block[15] = bit_len[31:0];
    sha_compress();
    digest = {chain_hash[0], chain_hash[1], chain_hash[2], chain_hash[3],
              chain_hash[4], chain_hash[5], chain_hash[6], chain_hash[7]};
    chain_hash    = HashInit;
    block_fill    = '0;
    msg_len_bytes = '0;
    return 1'b1;
  endfunction

  function automatic void queue_digest(input logic [255:0] digest);
    digest_word_t dw;
    for (int k = 0; k < 8; k++) begin
      dw.word  = digest[255 - 32 * k -: 32];
      dw.index = 3'(k);
      dw.last  = (3'(k) == sha256_pkg::LastWord);
      pending_words = {pending_words, dw};
    end
  endfunction

  function automatic void check_digest_word(input logic [31:0] word, input logic [2:0] index,
                                            input logic last);
    digest_word_t exp_w;
    if (pending_words.size() == 0) begin
      $error("unexpected digest word %h, index %0d", word, index);
      mismatches++;
      return;
    end
    exp_w = pending_words.pop_front();
    if (word !== exp_w.word) begin
      $error("digest_word: expected %h, got %h", exp_w.word, word);
      mismatches++;
    end
    if (index !== exp_w.index) begin
      $error("word_index: expected %0d, got %0d", exp_w.index, index);
      mismatches++;
    end
    if (last !== exp_w.last) begin
      $error("last_word: expected %0b, got %0b", exp_w.last, last);
      mismatches++;
    end
  endfunction

  // Offer one request, with an optional idle burst first, and hold until taken
  task automatic offer_item(input logic [7:0] d, input logic v, input logic e);
    if (sender_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= v;
    s_axis_tlast  <= e;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
  endtask

  task automatic apply_item(input logic [7:0] d, input logic v, input logic e,
                            input logic typed = 1'b0, input logic [255:0] known = '0);
    logic [255:0] digest;
    offer_item(d, v, e);
    items_sent++;
    if (sha_absorb(d, v, e, digest)) queue_digest(typed ? known : digest);
  endtask

  // Random message of len bytes, with idle noise; the last byte may ride on the end
  task automatic send_message(input int unsigned len);
    bit byte_on_end;
    byte_on_end = (len != 0) && ($urandom_range(0, 1) == 1);
    sender_gaps = ($urandom_range(0, 2) != 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) apply_item(8'($urandom), 1'b0, 1'b0);
      apply_item(8'($urandom), 1'b1, byte_on_end && (i == len - 1));
    end
    if (!byte_on_end) apply_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus: reset, directed table, random messages, then drain and report
  initial begin : stimulus
    int unsigned msg_no;
    int unsigned edge_no;
    int unsigned len;
    chain_hash    = HashInit;
    block_fill    = '0;
    msg_len_bytes = '0;
    msg_no        = 0;
    edge_no       = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDirRows; r++) begin
      apply_item(DirRows[r].data, DirRows[r].valid, DirRows[r].eom,
                 DirRows[r].typed, DirRows[r].digest);
    end

    while (items_sent < ItemBudget) begin
      if (items_sent >= QuietAfter) quiet_tail = 1'b1;
      if (msg_no % 3 == 1) begin
        len = EdgeLens[edge_no % 5];
        edge_no++;
      end else begin
        len = $urandom_range(0, 16);
      end
      send_message(len);
      // Let the pipeline run dry once before going on
      if (msg_no == 4) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      msg_no++;
    end
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sha256_message_digest_tb: clean");
    end else begin
      $display("sha256_message_digest_tb: errors");
    end
    $finish;
  end

  // Digest sink: check each word taken, stall in bursts, one long hold-off
  initial begin : digest_sink
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        check_digest_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        words_checked++;
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (!hold_done && words_checked >= HoldAfter) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      m_axis_tready <= (hold_left == 0 && stall_left == 0);
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("sha256_message_digest_tb: errors");
    $finish;
  end

endmodule

>>> filelist.f
hdl/sha256_pkg.sv
hdl/sha256_sched.sv
hdl/sha256_round.sv
hdl/sha256_message_digest.sv
tb/sha256_message_digest_tb.sv
